/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled during reset.
`define HSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`endif

/* hw/rtl/hsd_pkg.sv */
// Package for the hybrid source dispatch sequencer: types, codes, constants.
// No dependencies.
package hsd_pkg;

  typedef enum logic [3:0] {
    M_INIT    = 4'd0,
    M_WARM    = 4'd1,
    M_LOAD_DW = 4'd2,
    M_DIESEL  = 4'd3,
    M_LOAD_D  = 4'd4,
    M_BATT    = 4'd5,
    M_LOAD_B  = 4'd6,
    M_OPER    = 4'd7,
    M_DISABLE = 4'd8,
    M_END     = 4'd9,
    M_FAILED  = 4'd10,
    M_IDLE    = 4'd11,
    M_NONE    = 4'd15
  } mode_e;

  typedef enum logic [2:0] {
    R_SOURCE_MODE   = 3'd0,
    R_WARMING_MIN   = 3'd1,
    R_IDLE_MIN      = 3'd2,
    R_DIESEL_LIMIT  = 3'd3,
    R_CURRENT_LIMIT = 3'd4,
    R_BATT_MIN_V    = 3'd5,
    R_SHUTDOWN_HOUR = 3'd6,
    R_SHUTDOWN_MIN  = 3'd7
  } reg_idx_e;

  localparam int unsigned SettleTicks  = 1000;
  localparam int unsigned RampTicks    = 2000;
  localparam int unsigned StartTimeout = 10000;
  localparam int unsigned TicksPerMin  = 60000;

  localparam logic [26:0] PStep  = 27'd65536;
  localparam logic [26:0] PStart = 27'd327680;
  localparam logic signed [15:0] IStart = -16'sd160;
  localparam logic signed [16:0] IStep  = 17'sd80;

  localparam logic [14:0] Q87 = 15'd28508;
  localparam logic [14:0] Q86 = 15'd28180;
  localparam logic [14:0] Q84 = 15'd27525;
  localparam logic [14:0] Q82 = 15'd26870;
  localparam logic [14:0] Q97 = 15'd31785;
  localparam logic [14:0] Q95 = 15'd31130;
  localparam logic [14:0] Q93 = 15'd30474;
  localparam logic [14:0] Q90 = 15'd29491;

  typedef struct packed {
    logic              diesel_running;
    logic              converter_operating;
    logic              inverter_running;
    logic              protection_trip;
    logic signed [15:0] battery_voltage;
    logic [4:0]        clock_hour;
    logic [5:0]        clock_minute;
    logic [5:0]        clock_second;
  } in_req_t;

  typedef struct packed {
    logic [3:0]        mode_code;
    logic              inverter_on_request;
    logic              converter_enable;
    logic              diesel_start_request;
    logic              diesel_stop_request;
    logic [25:0]       diesel_power_ref;
    logic signed [15:0] battery_current_ref;
    logic              charge_profile_request;
  } out_req_t;

  typedef struct packed {
    logic [1:0]         source_mode;
    logic [7:0]         warming_minutes;
    logic [7:0]         idle_minutes;
    logic [25:0]        diesel_power_limit;
    logic signed [15:0] discharge_current_limit;
    logic [14:0]        battery_min_voltage;
    logic [4:0]         shutdown_hour;
    logic [5:0]         shutdown_minute;
  } cfg_t;

  // Precomputed thresholds derived from configuration.
  typedef struct packed {
    logic [24:0]        warm_limit;
    logic [24:0]        idle_limit;
    logic signed [16:0] e87;
    logic signed [16:0] e86;
    logic signed [16:0] e84;
    logic signed [16:0] e82;
    logic signed [16:0] c97;
    logic signed [16:0] c95;
    logic signed [16:0] c93;
    logic signed [16:0] c90;
  } thr_t;

endpackage

/* hw/rtl/hsd_cfg.sv */
// Configuration registers and registered thresholds derived from them.
// Depends on hsd_pkg.
module hsd_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output hsd_pkg::cfg_t     cfg_o,
  output hsd_pkg::thr_t     thr_o
);
  import hsd_pkg::*;

  cfg_t cfg_q, cfg_d;
  thr_t thr_q, thr_d;

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        R_SOURCE_MODE:   cfg_d.source_mode = cfg_data_i[1:0];
        R_WARMING_MIN:   cfg_d.warming_minutes = cfg_data_i[7:0];
        R_IDLE_MIN:      cfg_d.idle_minutes = cfg_data_i[7:0];
        R_DIESEL_LIMIT:  cfg_d.diesel_power_limit = cfg_data_i[25:0];
        R_CURRENT_LIMIT: cfg_d.discharge_current_limit = cfg_data_i[15:0];
        R_BATT_MIN_V:    cfg_d.battery_min_voltage = cfg_data_i[14:0];
        R_SHUTDOWN_HOUR: cfg_d.shutdown_hour = cfg_data_i[4:0];
        R_SHUTDOWN_MIN:  cfg_d.shutdown_minute = cfg_data_i[5:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  function automatic logic signed [16:0] edge_f(logic [14:0] v, logic [14:0] q);
    logic [29:0] p;
    p = v * q;
    return {2'b00, p[29:15]};
  endfunction

  // Floor of limit*q/32768 via arithmetic shift
  function automatic logic signed [16:0] cap_f(logic signed [15:0] l, logic [14:0] q);
    logic signed [31:0] p;
    p = l * $signed({1'b0, q});
    return p[31:15];
  endfunction

  // Derive thresholds from the next register values
  always_comb begin
    thr_d.warm_limit = 25'(cfg_d.warming_minutes * 17'(TicksPerMin));
    thr_d.idle_limit = 25'(cfg_d.idle_minutes * 17'(TicksPerMin));
    thr_d.e87 = edge_f(cfg_d.battery_min_voltage, Q87);
    thr_d.e86 = edge_f(cfg_d.battery_min_voltage, Q86);
    thr_d.e84 = edge_f(cfg_d.battery_min_voltage, Q84);
    thr_d.e82 = edge_f(cfg_d.battery_min_voltage, Q82);
    thr_d.c97 = cap_f(cfg_d.discharge_current_limit, Q97);
    thr_d.c95 = cap_f(cfg_d.discharge_current_limit, Q95);
    thr_d.c93 = cap_f(cfg_d.discharge_current_limit, Q93);
    thr_d.c90 = cap_f(cfg_d.discharge_current_limit, Q90);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      thr_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      thr_q <= thr_d;
    end
  end

  assign cfg_o = cfg_q;
  assign thr_o = thr_q;
endmodule

/* hw/rtl/hsd_core.sv */
// Sequencer state and per-tick next-state logic.
// Depends on hsd_pkg.
module hsd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  hsd_pkg::in_req_t in_i,
  input  hsd_pkg::cfg_t  cfg_i,
  input  hsd_pkg::thr_t  thr_i,
  output hsd_pkg::out_req_t res_o
);
  import hsd_pkg::*;

  mode_e mode_q, mode_d, prev_q, prev_d;
  logic [31:0] main_q, main_d, dcnt_q, dcnt_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [7:0] dtry_q, dtry_d, btry_q, btry_d;
  logic [26:0] dsp_q, dsp_d;
  logic signed [15:0] isp_q, isp_d;
  logic cen_q, cen_d;

  function automatic logic [31:0] inc32(logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction
  function automatic logic [15:0] inc16(logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction
  function automatic logic [7:0] inc8(logic [7:0] v);
    return (&v) ? v : v + 8'd1;
  endfunction
  function automatic logic signed [15:0] sat16(logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sh7fff;
    if (v < -17'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    logic d_on, c_op, inv, no_b, no_d, entered, done;
    logic signed [16:0] volt, cap;
    logic band;
    mode_e cur;
    d_on = in_i.diesel_running;
    c_op = in_i.converter_operating;
    inv  = in_i.inverter_running;
    no_b = cfg_i.source_mode[0];
    no_d = cfg_i.source_mode[1];
    volt = 17'(in_i.battery_voltage);
    done = 1'b0;
    band = 1'b0;
    cap  = '0;
    mode_d = mode_q; main_d = main_q; dcnt_d = dcnt_q; bcnt_d = bcnt_q;
    dtry_d = dtry_q; btry_d = btry_q; dsp_d = dsp_q; isp_d = isp_q; cen_d = cen_q;
    res_o = '0;
    // Force failed state on a protection trip
    cur = in_i.protection_trip ? M_FAILED : mode_q;
    entered = (cur != prev_q);
    prev_d = cur;
    mode_d = cur;

    unique case (cur)
      M_INIT: begin
        if (entered) begin
          btry_d = '0;
          dtry_d = '0;
        end
        mode_d = M_WARM;
        if (no_d) mode_d = M_BATT;
        if (no_b && no_d) mode_d = M_DISABLE;
      end
      M_WARM, M_DIESEL: begin
        if (entered) begin
          main_d = '0;
          dcnt_d = '0;
        end
        main_d = inc32(main_d);
        if (d_on) begin
          if (!inv) res_o.inverter_on_request = 1'b1;
          else begin
            dcnt_d = inc32(dcnt_d);
            if (cur == M_WARM) begin
              if (dcnt_d > {7'd0, thr_i.warm_limit}) mode_d = M_DIESEL;
            end else if (dcnt_d > RampTicks) begin
              dcnt_d = '0;
              dsp_d = dsp_d + PStep;
            end
          end
        end
        if (cur == M_DIESEL && dsp_d > {1'b0, cfg_i.diesel_power_limit}) begin
          dsp_d = {1'b0, cfg_i.diesel_power_limit};
          mode_d = M_BATT;
        end
        if (!d_on && dtry_d >= 8'd5) mode_d = M_BATT;
        if (main_d > SettleTicks) begin
          main_d = 32'(SettleTicks);
          if (!d_on && dtry_d < 8'd5 && !no_d) begin
            mode_d = (cur == M_WARM) ? M_LOAD_DW : M_LOAD_D;
            done = (cur == M_WARM);
          end
        end
        if (!done) begin
          if (no_b) cen_d = 1'b0;
          if (no_d) begin
            res_o.diesel_stop_request = 1'b1;
            mode_d = M_BATT;
          end
        end
      end
      M_BATT: begin
        if (entered) begin
          main_d = '0;
          bcnt_d = '0;
        end
        main_d = inc32(main_d);
        if (c_op) begin
          if (!inv) res_o.inverter_on_request = 1'b1;
          else begin
            bcnt_d = inc16(bcnt_d);
            if (bcnt_d > RampTicks) begin
              bcnt_d = '0;
              isp_d = sat16(17'(isp_d) - IStep);
            end
          end
        end
        if (isp_d < cfg_i.discharge_current_limit) begin
          isp_d = cfg_i.discharge_current_limit;
          mode_d = M_OPER;
        end
        if (!c_op && btry_d >= 8'd3) mode_d = M_OPER;
        if (main_d > SettleTicks) begin
          main_d = 32'(SettleTicks);
          if (!c_op && btry_d < 8'd3 && !no_b) mode_d = M_LOAD_B;
        end
        if (no_d) res_o.diesel_stop_request = 1'b1;
        if (no_b) begin
          cen_d = 1'b0;
          mode_d = M_OPER;
        end
      end
      M_OPER: begin
        if (entered) begin
          main_d = '0;
          bcnt_d = '0;
        end
        main_d = inc32(main_d);
        if (inv) begin
          if (in_i.clock_hour == cfg_i.shutdown_hour
              && in_i.clock_minute == cfg_i.shutdown_minute
              && in_i.clock_second < 6'd3) mode_d = M_DISABLE;
        end else mode_d = M_FAILED;
        // Pick the voltage band and its current cap
        if (volt < thr_i.e87 && volt >= thr_i.e86) begin
          band = 1'b1; cap = thr_i.c97;
        end else if (volt < thr_i.e86 && volt >= thr_i.e84) begin
          band = 1'b1; cap = thr_i.c95;
        end else if (volt < thr_i.e84 && volt >= thr_i.e82) begin
          band = 1'b1; cap = thr_i.c93;
        end else if (volt < thr_i.e82) begin
          band = 1'b1; cap = thr_i.c90;
        end
        if (band) begin
          bcnt_d = inc16(bcnt_d);
          if (bcnt_d > RampTicks) begin
            bcnt_d = '0;
            isp_d = sat16(17'(isp_d) + IStep);
            if (17'(isp_d) > cap) isp_d = cap[15:0];
          end
        end
        if (main_d > SettleTicks) begin
          main_d = 32'(SettleTicks);
          if (!c_op && btry_d < 8'd3 && !no_b) begin
            mode_d = M_LOAD_B; done = 1'b1;
          end else if (!d_on && dtry_d < 8'd3 && !no_d) begin
            mode_d = M_LOAD_D; done = 1'b1;
          end
        end
        if (!done) begin
          if (no_d) res_o.diesel_stop_request = 1'b1;
          if (no_b) cen_d = 1'b0;
          if (no_b && no_d) mode_d = M_DISABLE;
        end
      end
      M_DISABLE: begin
        if (entered) begin
          main_d = '0; bcnt_d = '0; dcnt_d = '0;
        end
        main_d = inc32(main_d);
        bcnt_d = inc16(bcnt_d);
        if (bcnt_d > RampTicks) begin
          bcnt_d = '0;
          isp_d = sat16(17'(isp_d) + IStep);
          if (isp_d > 16'sd0) isp_d = '0;
          dsp_d = (dsp_d < PStep) ? '0 : dsp_d - PStep;
        end
        if ((isp_d == 16'sd0 || !c_op) && (dsp_d == '0 || !d_on)) mode_d = M_END;
      end
      M_END, M_FAILED: begin
        if (entered) begin
          main_d = '0; dcnt_d = '0; bcnt_d = '0;
          cen_d = 1'b0;
          res_o.diesel_stop_request = 1'b1;
        end
        mode_d = M_IDLE;
      end
      M_IDLE: begin
        if (entered) begin
          main_d = '0; dcnt_d = '0; bcnt_d = '0;
        end
        main_d = inc32(main_d);
        if (main_d > {7'd0, thr_i.idle_limit}) res_o.charge_profile_request = 1'b1;
      end
      M_LOAD_B: begin
        if (entered) begin
          main_d = '0;
          isp_d = IStart;
          cen_d = 1'b1;
        end
        main_d = inc32(main_d);
        if (main_d > StartTimeout) begin
          btry_d = c_op ? '0 : inc8(btry_d);
          mode_d = M_BATT;
        end
      end
      M_LOAD_D, M_LOAD_DW: begin
        if (entered) begin
          main_d = '0;
          res_o.diesel_start_request = 1'b1;
          dsp_d = PStart;
        end
        main_d = inc32(main_d);
        if (main_d > StartTimeout) begin
          dtry_d = d_on ? '0 : inc8(dtry_d);
          mode_d = (cur == M_LOAD_D) ? M_DIESEL : M_WARM;
        end
      end
      default: ;
    endcase

    res_o.mode_code = mode_d;
    res_o.converter_enable = cen_d;
    res_o.diesel_power_ref = dsp_d[25:0];
    res_o.battery_current_ref = isp_d;
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_INIT; prev_q <= M_NONE;
      main_q <= '0; dcnt_q <= '0; bcnt_q <= '0;
      dtry_q <= '0; btry_q <= '0; dsp_q <= '0;
      isp_q <= IStart; cen_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; prev_q <= prev_d;
      main_q <= main_d; dcnt_q <= dcnt_d; bcnt_q <= bcnt_d;
      dtry_q <= dtry_d; btry_q <= btry_d; dsp_q <= dsp_d;
      isp_q <= isp_d; cen_q <= cen_d;
    end
  end
endmodule

/* hw/rtl/hybrid_source_dispatch_sequencer_top.sv */
// Top level of the hybrid source dispatch sequencer.
// Depends on hsd_pkg, hsd_cfg, hsd_core.
//
// Usage: one input request per 1 ms tick on in_valid_i/in_stall_o carrying
// device flags, battery voltage and clock time. Each tick yields one result
// request on out_valid_o/out_stall_i with the state code and commands.
// Configuration: cfg_valid_i/cfg_ready_o with register index and data; ready
// is always high. Write registers only while the block is idle.
// The input is registered; the sequencer logic runs on the input
// register and writes the result register once that register is free, so
// a stalled result delays the step.
// Throughput: one tick per cycle while the result is not stalled, set by
// the single pass of sequencer logic between the input and result registers.
// Stall: a stalled result holds; the input stage stalls only while both
// the input register and the result register are full and held.
// Reset: state returns to init, converter disabled, current setpoint -10 A,
// all configuration registers cleared.
module hybrid_source_dispatch_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsd_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsd_pkg::out_req_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import hsd_pkg::*;

  cfg_t cfg;
  thr_t thr;
  in_req_t in_q;
  out_req_t res, out_q;
  logic in_vld_q, out_vld_q, step, out_free;

  hsd_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg), .thr_o(thr)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  hsd_core u_core (
    .clk_i, .rst_ni, .step_i(step), .in_i(in_q), .cfg_i(cfg), .thr_i(thr), .res_o(res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (!in_stall_o) in_vld_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (out_free) out_vld_q <= step;
  end
  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule

/* hw/rtl/hsd_checker.sv */
// Port-level checker for the sequencer top, with its bind.
// Depends on hsd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hsd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input hsd_pkg::out_req_t out_data_o
);
  import hsd_pkg::*;

  logic start_ok;

  // A start pulse is given on the first tick of a diesel loading state
  assign start_ok = (out_data_o.mode_code == M_LOAD_D) || (out_data_o.mode_code == M_LOAD_DW);

  // Hold a stalled result
  `HSD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  // Input stalls only while a result waits
  `HSD_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)
  // A start pulse comes only in a loading state
  `HSD_ASSERT(a_start_mode, out_valid_o && out_data_o.diesel_start_request |-> start_ok)
  // Unused codes never show
  `HSD_ASSERT(a_code_range, out_valid_o |-> out_data_o.mode_code <= M_IDLE)
endmodule

bind hybrid_source_dispatch_sequencer_top hsd_checker u_hsd_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

/* sim/tb_top.sv */
// Self-checking testbench for the hybrid source dispatch sequencer top level.
// Depends on hsd_pkg and hybrid_source_dispatch_sequencer_top; it predicts each tick
// with its own sequencer model and compares every result request field by field.
module tb_top;
  import hsd_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomTicks   = 1000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall_o;
  in_req_t   in_data     = '0;
  logic      out_valid_o;
  logic      out_stall   = 1'b0;
  out_req_t  out_data_o;
  logic      cfg_valid   = 1'b0;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  hybrid_source_dispatch_sequencer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Sequencer copy: configuration
  logic [1:0]  src_mode;
  logic [7:0]  warm_min, idle_min;
  logic [25:0] dsl_limit;
  int          cur_limit;
  logic [14:0] vmin;
  logic [4:0]  fade_hh;
  logic [5:0]  fade_mm;

  // Sequencer copy: state
  logic [3:0]  mode, mode_prev;
  logic [31:0] main_cnt, dsl_cnt;
  logic [15:0] bat_cnt;
  logic [7:0]  dsl_tries, bat_tries;
  logic [31:0] dsl_set;
  int          cur_set;
  logic        conv_on;

  out_req_t pending_out[$];
  int unsigned errors = 0, checked = 0, ticks = 0;
  logic [15:0] modes_seen = '0;
  logic calm = 1'b0;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int band_edge(logic [14:0] q);
    longint unsigned p;
    p = longint'(vmin) * q;
    return int'(p >> 15);
  endfunction

  function automatic int current_cap(logic [14:0] q);
    longint p;
    p = longint'(cur_limit) * longint'(q);
    if (p >= 0) return int'(p >>> 15);
    return -int'((-p + 32767) >>> 15);
  endfunction

  // Ease the current back toward the band cap once per ramp period
  function automatic void backoff_step(int cap);
    bat_cnt = bat_cnt + (bat_cnt != '1);
    if (bat_cnt > RampTicks) begin
      bat_cnt = '0;
      cur_set = clamp16(cur_set + IStep);
      if (cur_set > cap) cur_set = cap;
    end
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [31:0] v);
    case (idx)
      R_SOURCE_MODE:   src_mode  = v[1:0];
      R_WARMING_MIN:   warm_min  = v[7:0];
      R_IDLE_MIN:      idle_min  = v[7:0];
      R_DIESEL_LIMIT:  dsl_limit = v[25:0];
      R_CURRENT_LIMIT: cur_limit = int'($signed(v[15:0]));
      R_BATT_MIN_V:    vmin      = v[14:0];
      R_SHUTDOWN_HOUR: fade_hh   = v[4:0];
      R_SHUTDOWN_MIN:  fade_mm   = v[5:0];
      default: ;
    endcase
  endfunction

  // Advance the sequencer by one tick and return the command set
  function automatic out_req_t sequence_tick(in_req_t t);
    out_req_t r;
    logic no_b, no_d, pow_on, start, stop, charge, entered, quit;
    int volt, e87, e86, e84, e82;
    no_b = src_mode[0];
    no_d = src_mode[1];
    pow_on = 0; start = 0; stop = 0; charge = 0; quit = 0;
    volt = int'(t.battery_voltage);
    if (t.protection_trip) mode = M_FAILED;
    entered = (mode != mode_prev);
    mode_prev = mode;
    case (mode)
      M_INIT: begin
        if (entered) begin bat_tries = '0; dsl_tries = '0; end
        mode = M_WARM;
        if (no_d) mode = M_BATT;
        if (no_b && no_d) mode = M_DISABLE;
      end
      M_WARM: begin
        if (entered) begin main_cnt = '0; dsl_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (t.diesel_running) begin
          if (!t.inverter_running) pow_on = 1;
          else begin
            dsl_cnt = dsl_cnt + (dsl_cnt != '1);
            if (longint'(dsl_cnt) > longint'(warm_min) * TicksPerMin) mode = M_DIESEL;
          end
        end
        if (!t.diesel_running && dsl_tries >= 5) mode = M_BATT;
        if (main_cnt > SettleTicks) begin
          main_cnt = SettleTicks;
          if (!t.diesel_running && dsl_tries < 5 && !no_d) begin
            mode = M_LOAD_DW; quit = 1;
          end
        end
        if (!quit) begin
          if (no_b) conv_on = 0;
          if (no_d) begin stop = 1; mode = M_BATT; end
        end
      end
      M_DIESEL: begin
        if (entered) begin main_cnt = '0; dsl_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (t.diesel_running) begin
          if (!t.inverter_running) pow_on = 1;
          else begin
            dsl_cnt = dsl_cnt + (dsl_cnt != '1);
            if (dsl_cnt > RampTicks) begin dsl_cnt = '0; dsl_set = dsl_set + PStep; end
          end
        end
        if (dsl_set > dsl_limit) begin dsl_set = dsl_limit; mode = M_BATT; end
        if (!t.diesel_running && dsl_tries >= 5) mode = M_BATT;
        if (main_cnt > SettleTicks) begin
          main_cnt = SettleTicks;
          if (!t.diesel_running && dsl_tries < 5 && !no_d) mode = M_LOAD_D;
        end
        if (no_b) conv_on = 0;
        if (no_d) begin stop = 1; mode = M_BATT; end
      end
      M_BATT: begin
        if (entered) begin main_cnt = '0; bat_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (t.converter_operating) begin
          if (!t.inverter_running) pow_on = 1;
          else begin
            bat_cnt = bat_cnt + (bat_cnt != '1);
            if (bat_cnt > RampTicks) begin bat_cnt = '0; cur_set = clamp16(cur_set - IStep); end
          end
        end
        if (cur_set < cur_limit) begin cur_set = cur_limit; mode = M_OPER; end
        if (!t.converter_operating && bat_tries >= 3) mode = M_OPER;
        if (main_cnt > SettleTicks) begin
          main_cnt = SettleTicks;
          if (!t.converter_operating && bat_tries < 3 && !no_b) mode = M_LOAD_B;
        end
        if (no_d) stop = 1;
        if (no_b) begin conv_on = 0; mode = M_OPER; end
      end
      M_OPER: begin
        e87 = band_edge(Q87); e86 = band_edge(Q86);
        e84 = band_edge(Q84); e82 = band_edge(Q82);
        if (entered) begin main_cnt = '0; bat_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (t.inverter_running) begin
          if (t.clock_hour == fade_hh && t.clock_minute == fade_mm && t.clock_second < 3)
            mode = M_DISABLE;
        end else mode = M_FAILED;
        if (volt < e87 && volt >= e86) backoff_step(current_cap(Q97));
        else if (volt < e86 && volt >= e84) backoff_step(current_cap(Q95));
        else if (volt < e84 && volt >= e82) backoff_step(current_cap(Q93));
        else if (volt < e82) backoff_step(current_cap(Q90));
        if (main_cnt > SettleTicks) begin
          main_cnt = SettleTicks;
          if (!t.converter_operating && bat_tries < 3 && !no_b) begin
            mode = M_LOAD_B; quit = 1;
          end else if (!t.diesel_running && dsl_tries < 3 && !no_d) begin
            mode = M_LOAD_D; quit = 1;
          end
        end
        if (!quit) begin
          if (no_d) stop = 1;
          if (no_b) conv_on = 0;
          if (no_b && no_d) mode = M_DISABLE;
        end
      end
      M_DISABLE: begin
        if (entered) begin main_cnt = '0; bat_cnt = '0; dsl_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        bat_cnt = bat_cnt + (bat_cnt != '1);
        if (bat_cnt > RampTicks) begin
          bat_cnt = '0;
          cur_set = clamp16(cur_set + IStep);
          if (cur_set > 0) cur_set = 0;
          dsl_set = (dsl_set < PStep) ? 32'd0 : dsl_set - PStep;
        end
        if ((cur_set == 0 || !t.converter_operating) && (dsl_set == 0 || !t.diesel_running))
          mode = M_END;
      end
      M_END, M_FAILED: begin
        if (entered) begin
          main_cnt = '0; dsl_cnt = '0; bat_cnt = '0; conv_on = 0; stop = 1;
        end
        mode = M_IDLE;
      end
      M_IDLE: begin
        if (entered) begin main_cnt = '0; dsl_cnt = '0; bat_cnt = '0; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (longint'(main_cnt) > longint'(idle_min) * TicksPerMin) charge = 1;
      end
      M_LOAD_B: begin
        if (entered) begin main_cnt = '0; cur_set = IStart; conv_on = 1; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (main_cnt > StartTimeout) begin
          if (t.converter_operating) bat_tries = '0;
          else bat_tries = bat_tries + (bat_tries != '1);
          mode = M_BATT;
        end
      end
      M_LOAD_D, M_LOAD_DW: begin
        if (entered) begin main_cnt = '0; start = 1; dsl_set = PStart; end
        main_cnt = main_cnt + (main_cnt != '1);
        if (main_cnt > StartTimeout) begin
          if (t.diesel_running) dsl_tries = '0;
          else dsl_tries = dsl_tries + (dsl_tries != '1);
          mode = (mode == M_LOAD_D) ? M_DIESEL : M_WARM;
        end
      end
      default: ;
    endcase
    r.mode_code              = mode;
    r.inverter_on_request    = pow_on;
    r.converter_enable       = conv_on;
    r.diesel_start_request   = start;
    r.diesel_stop_request    = stop;
    r.diesel_power_ref       = dsl_set[25:0];
    r.battery_current_ref    = cur_set[15:0];
    r.charge_profile_request = charge;
    return r;
  endfunction

  // Send one tick request, idling at random first; record its prediction
  task automatic send_tick(in_req_t t);
    out_req_t r;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (in_stall_o);
    r = sequence_tick(t);
    pending_out.push_back(r);
    modes_seen[r.mode_code] = 1'b1;
    ticks++;
  endtask

  // Drop the input and wait until every result has drained
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; valid is lowered by the caller after the batch
  task automatic cfg_write(reg_idx_e idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, v);
  endtask

  task automatic report(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // Result side: random stall, compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_req_t e;
    if (out_valid_o && !out_stall && rst_ni) begin
      if (pending_out.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_data_o);
        errors++;
      end else begin
        e = pending_out.pop_front();
        checked++;
        report("mode_code", e.mode_code, out_data_o.mode_code);
        report("inverter_on_request", e.inverter_on_request, out_data_o.inverter_on_request);
        report("converter_enable", e.converter_enable, out_data_o.converter_enable);
        report("diesel_start_request", e.diesel_start_request, out_data_o.diesel_start_request);
        report("diesel_stop_request", e.diesel_stop_request, out_data_o.diesel_stop_request);
        report("diesel_power_ref", e.diesel_power_ref, out_data_o.diesel_power_ref);
        report("battery_current_ref", e.battery_current_ref, out_data_o.battery_current_ref);
        report("charge_profile_request", e.charge_profile_request,
               out_data_o.charge_profile_request);
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  // Watchdog: end the run when no channel moves for too long
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      quiet <= 0;
    else if (rst_ni) quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("%0t watchdog: no request moved for %0d cycles", $time, quiet);
      $display("[hybrid_source_dispatch_sequencer_top] ERROR");
      $finish;
    end
  end

  typedef struct {
    in_req_t  d;
    bit       chk;
    out_req_t e;
  } row_t;

  row_t dir_tbl[];
  out_req_t warm_rst;

  initial begin
    in_req_t t;
    out_req_t got;
    logic d_on, c_op;
    int unsigned oper_ticks, idle_ticks, n;
    int unsigned v;

    src_mode = '0; warm_min = '0; idle_min = '0; dsl_limit = '0; cur_limit = 0;
    vmin = '0; fade_hh = '0; fade_mm = '0;
    mode = M_INIT; mode_prev = M_NONE; main_cnt = '0; dsl_cnt = '0; bat_cnt = '0;
    dsl_tries = '0; bat_tries = '0; dsl_set = '0; cur_set = IStart; conv_on = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    warm_rst = '{M_WARM, 1'b0, 1'b0, 1'b0, 1'b0, 26'd0, -16'sd160, 1'b0};
    // Directed ticks: first two read straight off the reset state, then field extremes
    dir_tbl = '{
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 5'd0, 6'd0, 6'd0}, 1'b1, warm_rst},
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 5'd0, 6'd0, 6'd0}, 1'b1, warm_rst},
      '{'{1'b1, 1'b1, 1'b1, 1'b0, 16'sd32767, 5'd23, 6'd59, 6'd59}, 1'b0, warm_rst},
      '{'{1'b1, 1'b1, 1'b0, 1'b0, -16'sd32768, 5'd0, 6'd0, 6'd0}, 1'b0, warm_rst},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, -16'sd1, 5'd31, 6'd63, 6'd63}, 1'b0, warm_rst},
      '{'{1'b1, 1'b0, 1'b1, 1'b0, 16'sd0, 5'd31, 6'd0, 6'd63}, 1'b0, warm_rst},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 16'sh5555, 5'd10, 6'd42, 6'd21}, 1'b0, warm_rst},
      '{'{1'b1, 1'b1, 1'b1, 1'b0, 16'sh2AAA, 5'd21, 6'd21, 6'd42}, 1'b0, warm_rst},
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd800, 5'd6, 6'd30, 6'd2}, 1'b0, warm_rst},
      '{'{1'b1, 1'b1, 1'b0, 1'b0, 16'sd700, 5'd6, 6'd30, 6'd0}, 1'b0, warm_rst}
    };
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].chk && (sequence_tick(dir_tbl[i].d) !== dir_tbl[i].e)) begin
        $display("%0t directed row %0d: expected %h predicted otherwise", $time, i,
                 dir_tbl[i].e);
        errors++;
      end
      // Roll back the check above: the tick is predicted for real in send_tick
      if (dir_tbl[i].chk) begin
        mode = (i == 0) ? M_INIT : M_WARM;
        mode_prev = (i == 0) ? M_NONE : M_INIT;
        main_cnt = '0;
      end
      send_tick(dir_tbl[i].d);
    end

    // Working setting: short warm-up, a diesel limit below the start power, a few ramp steps on the battery
    drain();
    cfg_write(R_SOURCE_MODE, 32'd0);
    cfg_write(R_WARMING_MIN, 32'd0);
    cfg_write(R_IDLE_MIN, 32'd0);
    cfg_write(R_DIESEL_LIMIT, 32'd3 << 16 | 32'd123);
    cfg_write(R_CURRENT_LIMIT, -32'sd400);
    cfg_write(R_BATT_MIN_V, 32'd800);
    cfg_write(R_SHUTDOWN_HOUR, 32'd6);
    cfg_write(R_SHUTDOWN_MIN, 32'd30);
    cfg_valid <= 1'b0;

    // Random ticks: flags held for stretches so the sequence walks its states
    d_on = 1'b0; c_op = 1'b0; oper_ticks = 0; idle_ticks = 0;
    for (n = 0; n < RandomTicks && idle_ticks < 3000; n++) begin
      calm = (n >= 400 && n < 700);
      if (n != 0 && n % 400 == 0 && mode != M_IDLE) begin
        drain();
        cfg_write(R_BATT_MIN_V, $urandom_range(0, 32767));
        cfg_write(R_CURRENT_LIMIT, -$urandom_range(0, 800));
        cfg_write(R_DIESEL_LIMIT, $urandom_range(0, 6) << 16 | $urandom_range(0, 65535));
        cfg_write(R_WARMING_MIN, $urandom_range(0, 1) == 0 ? 0 : 0);
        cfg_write(R_SHUTDOWN_HOUR, $urandom_range(0, 23));
        cfg_write(R_SHUTDOWN_MIN, $urandom_range(0, 59));
        cfg_valid <= 1'b0;
      end
      if ($urandom_range(0, (mode == M_DISABLE) ? 29 : 299) == 0) d_on = ~d_on;
      if ($urandom_range(0, (mode == M_DISABLE) ? 29 : 299) == 0) c_op = ~c_op;
      t.diesel_running      = d_on;
      t.converter_operating = c_op;
      t.inverter_running    = (mode == M_OPER) ? ($urandom_range(0, 49999) != 0)
                                               : ($urandom_range(0, 15) != 0);
      t.protection_trip     = ($urandom_range(0, 59999) == 0);
      if ($urandom_range(0, 3) == 0) t.battery_voltage = $urandom();
      else begin
        v = (int'(vmin) * $urandom_range(78, 100)) / 100;
        t.battery_voltage = v[15:0];
      end
      if ($urandom_range(0, 7) == 0) begin
        t.clock_hour = $urandom(); t.clock_minute = $urandom(); t.clock_second = $urandom();
      end else begin
        t.clock_hour = $urandom_range(0, 23);
        t.clock_minute = $urandom_range(0, 59);
        t.clock_second = $urandom_range(0, 59);
      end
      // Hit the daily fade window once supervised operation has run a while
      if (mode == M_OPER && oper_ticks > 120 && $urandom_range(0, 99) == 0) begin
        t.clock_hour = fade_hh; t.clock_minute = fade_mm;
        t.clock_second = $urandom_range(0, 2);
      end
      if (mode == M_OPER) oper_ticks++;
      if (mode == M_IDLE) idle_ticks++;
      send_tick(t);
    end
    calm = 1'b0;

    // Extreme settings, then a trip from idle and the charge request
    drain();
    cfg_write(R_SOURCE_MODE, 32'd3);
    cfg_write(R_WARMING_MIN, 32'd255);
    cfg_write(R_IDLE_MIN, 32'd255);
    cfg_write(R_DIESEL_LIMIT, 32'h3FFFFFF);
    cfg_write(R_CURRENT_LIMIT, -32'sd32768);
    cfg_write(R_BATT_MIN_V, 32'd32767);
    cfg_write(R_SHUTDOWN_HOUR, 32'd23);
    cfg_write(R_SHUTDOWN_MIN, 32'd59);
    cfg_valid <= 1'b0;
    for (n = 0; n < 300; n++) begin
      t = $urandom();
      t.protection_trip = (n == 100 || n == 101 || n == 250);
      send_tick(t);
    end
    drain();
    cfg_write(R_IDLE_MIN, 32'd0);
    cfg_write(R_CURRENT_LIMIT, 32'd32767);
    cfg_write(R_SOURCE_MODE, 32'd1);
    cfg_valid <= 1'b0;
    for (n = 0; n < 200; n++) begin
      t = $urandom();
      t.protection_trip = (n == 20);
      send_tick(t);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d ticks, checked %0d results, state codes reached (bit per code): %b",
             ticks, checked, modes_seen);
    if (errors == 0 && pending_out.size() == 0) begin
      $display("[hybrid_source_dispatch_sequencer_top] OK");
    end else begin
      $display("[hybrid_source_dispatch_sequencer_top] ERROR");
    end
    $finish;
  end
endmodule
